// File: rtl/core/tlb_pkg.sv
// ----------------------------------------------------------------------------
// tlb_pkg
// Shared types and constants of the fully associative translation buffer:
// field widths, command and mode codes, register indexes and cell records.
// ----------------------------------------------------------------------------
package tlb_pkg;

  localparam int PID_W      = 16;
  localparam int PAGE_W     = 32;
  localparam int FRAME_W    = 32;
  localparam int CFG_DATA_W = 6;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_DATA_W-1:0] ENTRIES_RST = 6'd32;

  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_INSERT = 1'b1
  } cmd_t;

  typedef enum logic {
    MODE_FIFO = 1'b0,
    MODE_LRU  = 1'b1
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENTRIES_IN_USE = 1'b0,
    REG_REPL_MODE      = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_t;

  typedef struct packed {
    logic [PID_W-1:0]   process_id;
    logic [PAGE_W-1:0]  page_number;
    logic [FRAME_W-1:0] frame_number;
  } entry_t;

  // Per-cell update controls for one cycle.
  typedef struct packed {
    logic load;    // take the new entry
    logic shift;   // take the entry handed down by the upper neighbour
    logic mru;     // entry was hit: becomes most recently used
    logic dec_en;  // close the gap left in the recency order
  } cell_op_t;

  typedef struct packed {
    logic match;
    logic rank_zero;
  } cell_stat_t;

endpackage

// File: rtl/core/tlb_req_if.sv
// ----------------------------------------------------------------------------
// tlb_req_if
// Request channel: command and key, plus the frame carried by an insert.
// ----------------------------------------------------------------------------
interface tlb_req_if;
  import tlb_pkg::*;

  logic               valid;
  logic               ready;
  cmd_t               command;
  logic [PID_W-1:0]   process_id;
  logic [PAGE_W-1:0]  page_number;
  logic [FRAME_W-1:0] frame_number;

  modport source (
    output valid, command, process_id, page_number, frame_number,
    input  ready
  );

  modport sink (
    input  valid, command, process_id, page_number, frame_number,
    output ready
  );

endinterface

// File: rtl/core/tlb_rsp_if.sv
// ----------------------------------------------------------------------------
// tlb_rsp_if
// Result channel: hit flag, translated frame and eviction flag.
// ----------------------------------------------------------------------------
interface tlb_rsp_if;
  import tlb_pkg::*;

  logic               valid;
  logic               ready;
  logic               hit;
  logic [FRAME_W-1:0] frame_found;
  logic               evicted;

  modport source (
    output valid, hit, frame_found, evicted,
    input  ready
  );

  modport sink (
    input  valid, hit, frame_found, evicted,
    output ready
  );

endinterface

// File: rtl/core/tlb_cell.sv
// ----------------------------------------------------------------------------
// tlb_cell
// One entry of the translation buffer. Cells sit in insertion order, so the
// position is the age; each cell keeps its recency rank and can take the
// entry of its upper neighbour when an entry below it is removed.
// ----------------------------------------------------------------------------
module tlb_cell #(
  parameter int RANK_W = 5
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tlb_pkg::cell_op_t            op,
  input  logic [tlb_pkg::PID_W-1:0]    key_pid,
  input  logic [tlb_pkg::PAGE_W-1:0]   key_page,
  input  logic [RANK_W-1:0]            ref_rank,
  input  logic [RANK_W-1:0]            set_rank,
  input  tlb_pkg::entry_t              ins_entry,
  input  logic                         nb_valid,
  input  tlb_pkg::entry_t              nb_entry,
  input  logic [RANK_W-1:0]            nb_rank,
  output logic                         valid,
  output tlb_pkg::entry_t              entry,
  output logic [RANK_W-1:0]            rank,
  output logic [RANK_W-1:0]            hand_rank,
  output tlb_pkg::cell_stat_t          stat
);
  import tlb_pkg::*;

  logic              valid_r;
  logic [RANK_W-1:0] rank_r;
  entry_t            entry_r;
  logic              newer;

  // Entries more recent than the one that moves or leaves drop one place.
  assign newer     = valid_r && op.dec_en && (rank_r > ref_rank);
  assign hand_rank = newer ? rank_r - 1'b1 : rank_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rank_r  <= '0;
    end else begin
      priority if (op.load) begin
        valid_r <= 1'b1;
        rank_r  <= set_rank;
      end else if (op.shift) begin
        valid_r <= nb_valid;
        rank_r  <= nb_rank;
      end else if (op.mru) begin
        rank_r  <= set_rank;
      end else begin
        rank_r  <= hand_rank;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (op.load) begin
      entry_r <= ins_entry;
    end else if (op.shift) begin
      entry_r <= nb_entry;
    end else begin
      entry_r <= entry_r;
    end
  end

  assign stat.match     = valid_r && (entry_r.process_id == key_pid) &&
                          (entry_r.page_number == key_page);
  assign stat.rank_zero = valid_r && (rank_r == '0);

  assign valid = valid_r;
  assign entry = entry_r;
  assign rank  = rank_r;

endmodule

// File: rtl/core/tlb_fifo_lru_translation.sv
// ----------------------------------------------------------------------------
// tlb_fifo_lru_translation
// Fully associative translation buffer with FIFO or LRU replacement.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one request item: a lookup (key process_id, page_number)
//   or an insert (key plus frame_number). out_chan returns exactly one result
//   item per request: hit and frame_found for a lookup, evicted for an insert.
//   The cfg port writes entries_in_use (index 0) and replacement_mode
//   (index 1); write it only while no request is in flight.
// Timing:
//   An item is compared against all cells in the cycle after acceptance and
//   the cells are updated in the update state that follows, once the result
//   register is free, when the result item is registered. A new item can be
//   taken in that update state, so the block accepts the next item while
//   the last one is still being updated.
// Reset and stalls:
//   Reset empties the buffer (all cells invalid) and restores capacity 32 and
//   FIFO mode. A stalled receiver holds the result item; the block still
//   accepts one further item and holds it before its update until the
//   result register frees.
// ----------------------------------------------------------------------------
module tlb_fifo_lru_translation #(
  parameter int MAX_ENTRIES = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  tlb_req_if.sink                           in_chan,
  tlb_rsp_if.source                         out_chan,
  input  logic                              cfg_wr_en,
  input  logic [tlb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tlb_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import tlb_pkg::*;

  localparam int N      = MAX_ENTRIES;
  localparam int RANK_W = (N > 1) ? $clog2(N) : 1;
  localparam int CNT_W  = $clog2(N + 1);
  localparam int CW     = (CNT_W > CFG_DATA_W) ? CNT_W : CFG_DATA_W;

  state_t                st_r, st_nxt;
  logic [CFG_DATA_W-1:0] cfg_entries_r;
  mode_t                 cfg_mode_r;
  cmd_t                  cmd_r;
  entry_t                key_r;
  logic [CNT_W-1:0]      occ_r, occ_nxt;
  logic [N-1:0]          match_r, lru0_r;
  logic                  out_valid_r, out_hit_r, out_evicted_r;
  logic [FRAME_W-1:0]    out_frame_r;

  logic                  in_acc, out_free, upd_go;
  logic                  is_lookup, found, need_evict;
  logic [N-1:0]          match_v, lru_v, hit_oh, victim_oh, sel_oh, ge_mask;
  logic [CW-1:0]         ent_w, cap;
  logic [CNT_W-1:0]      new_pos;
  logic [RANK_W-1:0]     sel_rank, set_rank;
  logic [FRAME_W-1:0]    hit_frame;

  logic                  cell_valid [N];
  entry_t                cell_entry [N];
  logic [RANK_W-1:0]     cell_rank  [N];
  logic [RANK_W-1:0]     cell_hand  [N];
  cell_stat_t            cell_stat  [N];
  cell_op_t              cell_op    [N];
  logic                  nb_valid   [N];
  entry_t                nb_entry   [N];
  logic [RANK_W-1:0]     nb_rank    [N];

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_entries_r <= ENTRIES_RST;
      cfg_mode_r    <= MODE_FIFO;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ENTRIES_IN_USE: cfg_entries_r <= cfg_wdata;
        REG_REPL_MODE:      cfg_mode_r    <= mode_t'(cfg_wdata[0]);
      endcase
    end
  end

  // ------------------------------------------------------------ sequencer
  assign in_acc   = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (in_acc) st_nxt = ST_CMP;
      ST_CMP:  st_nxt = ST_UPD;
      ST_UPD: begin
        if (out_free) st_nxt = in_acc ? ST_CMP : ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_chan.ready = 1'b0;
    upd_go        = 1'b0;
    unique case (st_r)
      ST_IDLE: in_chan.ready = 1'b1;
      ST_CMP:  in_chan.ready = 1'b0;
      ST_UPD: begin
        in_chan.ready = out_free;
        upd_go        = out_free;
      end
      default: in_chan.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r                <= in_chan.command;
      key_r.process_id     <= in_chan.process_id;
      key_r.page_number    <= in_chan.page_number;
      key_r.frame_number   <= in_chan.frame_number;
    end
    if (st_r == ST_CMP) begin
      match_r <= match_v;
      lru0_r  <= lru_v;
    end
  end

  // ---------------------------------------------------------- update logic
  assign is_lookup = (cmd_r == CMD_LOOKUP);
  assign found     = |match_r;
  // The lowest cell is the earliest inserted, so it wins among several hits.
  assign hit_oh    = match_r & (~match_r + N'(1));
  assign victim_oh = (cfg_mode_r == MODE_LRU) ? lru0_r : N'(1);
  assign sel_oh    = is_lookup ? hit_oh : victim_oh;
  assign ge_mask   = ~(victim_oh - N'(1));

  assign ent_w = CW'(cfg_entries_r);
  assign cap   = (ent_w == '0) ? CW'(1) : ((ent_w > CW'(N)) ? CW'(N) : ent_w);

  assign need_evict = !is_lookup && (CW'(occ_r) >= cap);
  assign new_pos    = need_evict ? occ_r - 1'b1 : occ_r;
  assign set_rank   = is_lookup ? RANK_W'(occ_r - 1'b1) : RANK_W'(new_pos);

  always_comb begin
    sel_rank  = '0;
    hit_frame = '0;
    for (int i = 0; i < N; i++) begin
      sel_rank  = sel_rank  | (sel_oh[i] ? cell_rank[i] : '0);
      hit_frame = hit_frame | (hit_oh[i] ? cell_entry[i].frame_number : '0);
    end
  end

  always_comb begin
    occ_nxt = occ_r;
    if (upd_go && !is_lookup && !need_evict) begin
      occ_nxt = occ_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  // ------------------------------------------------------------- cell row
  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == N - 1) begin : g_last
      assign nb_valid[i] = 1'b0;
      assign nb_entry[i] = '0;
      assign nb_rank[i]  = '0;
    end else begin : g_mid
      assign nb_valid[i] = cell_valid[i+1];
      assign nb_entry[i] = cell_entry[i+1];
      assign nb_rank[i]  = cell_hand[i+1];
    end

    assign cell_op[i].load   = upd_go && !is_lookup && (new_pos == CNT_W'(i));
    assign cell_op[i].shift  = upd_go && need_evict && ge_mask[i];
    assign cell_op[i].mru    = upd_go && is_lookup && hit_oh[i];
    assign cell_op[i].dec_en = upd_go && (is_lookup ? found : need_evict);

    assign match_v[i] = cell_stat[i].match;
    assign lru_v[i]   = cell_stat[i].rank_zero;

    tlb_cell #(
      .RANK_W (RANK_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .op        (cell_op[i]),
      .key_pid   (key_r.process_id),
      .key_page  (key_r.page_number),
      .ref_rank  (sel_rank),
      .set_rank  (set_rank),
      .ins_entry (key_r),
      .nb_valid  (nb_valid[i]),
      .nb_entry  (nb_entry[i]),
      .nb_rank   (nb_rank[i]),
      .valid     (cell_valid[i]),
      .entry     (cell_entry[i]),
      .rank      (cell_rank[i]),
      .hand_rank (cell_hand[i]),
      .stat      (cell_stat[i])
    );
  end

  // -------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (upd_go) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      out_hit_r     <= is_lookup && found;
      out_frame_r   <= (is_lookup && found) ? hit_frame : '0;
      out_evicted_r <= need_evict;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.hit         = out_hit_r;
  assign out_chan.frame_found = out_frame_r;
  assign out_chan.evicted     = out_evicted_r;

endmodule

// File: rtl/core/tlb_chk.sv
// ----------------------------------------------------------------------------
// tlb_chk
// Port-level checker for the translation buffer, bound to the top level.
// ----------------------------------------------------------------------------
module tlb_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_hit,
  input logic [tlb_pkg::FRAME_W-1:0]   out_frame,
  input logic                          out_evicted
);

  // An accepted item occupies the compare stage, so no item follows at once.
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted in the cycle after an acceptance");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_hit) &&
                                   $stable(out_frame) && $stable(out_evicted)))
    else $error("stalled result item changed");

  a_hit_or_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_evicted))
    else $error("result item reports both a hit and an eviction");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_frame == '0))
    else $error("frame is not zero on a result item without a hit");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item valid after reset");

endmodule

bind tlb_fifo_lru_translation tlb_chk u_tlb_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_hit     (out_chan.hit),
  .out_frame   (out_chan.frame_found),
  .out_evicted (out_chan.evicted)
);
